// ===== src/lbmeq_pkg.sv =====
`timescale 1ns / 1ps

package lbmeq_pkg;

    // Field widths of the two channels.
    localparam int C_POP_W = 32;
    localparam int C_DIR_W = 5;
    localparam int C_OUT_W = 32;

    // Per-cell accumulators carry five guard bits above the Q7.24 word.
    localparam int C_ACC_W = 37;

    // Velocity components are -1, 0 or +1.
    localparam logic signed [1:0] C_VEL_POS  = 2'sb01;
    localparam logic signed [1:0] C_VEL_NEG  = 2'sb11;
    localparam logic signed [1:0] C_VEL_ZERO = 2'sb00;

    typedef logic signed [C_ACC_W-1:0] t_acc;

    typedef struct packed {
        logic signed [1:0] cx;
        logic signed [1:0] cy;
        logic signed [1:0] cz;
    } t_vel;

    // Raw sums of one finished cell, handed from the front to the back.
    typedef struct packed {
        t_acc rho;
        t_acc mx;
        t_acc my;
        t_acc mz;
    } t_snap;

    // D3Q19 lattice velocity table; the first seven entries form D3Q7.
    function automatic t_vel f_vel(logic [C_DIR_W-1:0] dir);
        t_vel v;
        v = '{cx: C_VEL_ZERO, cy: C_VEL_ZERO, cz: C_VEL_ZERO};
        unique case (dir)
            5'd1:  v.cx = C_VEL_POS;
            5'd2:  v.cx = C_VEL_NEG;
            5'd3:  v.cy = C_VEL_POS;
            5'd4:  v.cy = C_VEL_NEG;
            5'd5:  v.cz = C_VEL_POS;
            5'd6:  v.cz = C_VEL_NEG;
            5'd7:  begin v.cx = C_VEL_POS; v.cy = C_VEL_POS; end
            5'd8:  begin v.cx = C_VEL_POS; v.cy = C_VEL_NEG; end
            5'd9:  begin v.cx = C_VEL_POS; v.cz = C_VEL_POS; end
            5'd10: begin v.cx = C_VEL_POS; v.cz = C_VEL_NEG; end
            5'd11: begin v.cy = C_VEL_POS; v.cz = C_VEL_POS; end
            5'd12: begin v.cy = C_VEL_POS; v.cz = C_VEL_NEG; end
            5'd13: begin v.cx = C_VEL_NEG; v.cy = C_VEL_POS; end
            5'd14: begin v.cx = C_VEL_NEG; v.cy = C_VEL_NEG; end
            5'd15: begin v.cx = C_VEL_NEG; v.cz = C_VEL_POS; end
            5'd16: begin v.cx = C_VEL_NEG; v.cz = C_VEL_NEG; end
            5'd17: begin v.cy = C_VEL_NEG; v.cz = C_VEL_POS; end
            5'd18: begin v.cy = C_VEL_NEG; v.cz = C_VEL_NEG; end
            default: v = '{cx: C_VEL_ZERO, cy: C_VEL_ZERO, cz: C_VEL_ZERO};
        endcase
        return v;
    endfunction

endpackage

// ===== src/lbmeq_in_if.sv =====
`timescale 1ns / 1ps

interface lbmeq_in_if import lbmeq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [C_POP_W-1:0] population;
    logic [C_DIR_W-1:0]        direction;
    logic                      last_in;

    modport source (output valid, population, direction, last_in, input ready);
    modport sink   (input valid, population, direction, last_in, output ready);
endinterface

// ===== src/lbmeq_out_if.sv =====
`timescale 1ns / 1ps

interface lbmeq_out_if import lbmeq_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [C_OUT_W-1:0] equilibrium;
    logic [C_DIR_W-1:0]        out_direction;
    logic                      last_out;

    modport source (output valid, equilibrium, out_direction, last_out, input ready);
    modport sink   (input valid, equilibrium, out_direction, last_out, output ready);
endinterface

// ===== src/lbmeq_front.sv =====
`timescale 1ns / 1ps

module lbmeq_front import lbmeq_pkg::*; #(
    parameter int NUM_DIRS = 19
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lbmeq_in_if.sink   i_in,
    output logic       o_snap_valid,
    output t_snap      o_snap,
    input  logic       i_snap_ready
);

    localparam int SUM_W = C_ACC_W + 1;

    // Saturating add of +pop, -pop or nothing into one accumulator.
    function automatic t_acc f_acc_add(t_acc acc, logic signed [C_POP_W-1:0] pop,
                                       logic signed [1:0] c);
        logic signed [SUM_W-1:0] term;
        logic signed [SUM_W-1:0] sum;
        term = SUM_W'(pop);
        case (c)
            C_VEL_POS: sum = SUM_W'(acc) + term;
            C_VEL_NEG: sum = SUM_W'(acc) - term;
            default:   sum = SUM_W'(acc);
        endcase
        if (sum[SUM_W-1] != sum[SUM_W-2]) begin
            return sum[SUM_W-1] ? {1'b1, {(C_ACC_W-1){1'b0}}} : {1'b0, {(C_ACC_W-1){1'b1}}};
        end
        return sum[C_ACC_W-1:0];
    endfunction

    t_acc              r_rho, r_mx, r_my, r_mz;
    t_acc              n_rho, n_mx, n_my, n_mz;
    t_vel              w_vel;
    logic              w_dir_ok;
    logic signed [1:0] w_cd;
    logic              w_accept;

    assign i_in.ready = i_snap_ready;
    assign w_accept   = i_in.valid & i_in.ready;
    assign w_dir_ok   = i_in.direction < C_DIR_W'(NUM_DIRS);

    always_comb begin
        w_vel = f_vel(i_in.direction);
        w_cd  = C_VEL_POS;
        if (!w_dir_ok) begin
            w_vel = '{cx: C_VEL_ZERO, cy: C_VEL_ZERO, cz: C_VEL_ZERO};
            w_cd  = C_VEL_ZERO;
        end
        n_rho = f_acc_add(r_rho, i_in.population, w_cd);
        n_mx  = f_acc_add(r_mx, i_in.population, w_vel.cx);
        n_my  = f_acc_add(r_my, i_in.population, w_vel.cy);
        n_mz  = f_acc_add(r_mz, i_in.population, w_vel.cz);
    end

    // The last item of a cell is pushed together with its own contribution.
    assign o_snap_valid = w_accept & i_in.last_in;
    assign o_snap       = '{rho: n_rho, mx: n_mx, my: n_my, mz: n_mz};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rho <= '0;
            r_mx  <= '0;
            r_my  <= '0;
            r_mz  <= '0;
        end else if (w_accept) begin
            if (i_in.last_in) begin
                r_rho <= '0;
                r_mx  <= '0;
                r_my  <= '0;
                r_mz  <= '0;
            end else begin
                r_rho <= n_rho;
                r_mx  <= n_mx;
                r_my  <= n_my;
                r_mz  <= n_mz;
            end
        end
    end

endmodule

// ===== src/lbmeq_queue.sv =====
`timescale 1ns / 1ps

module lbmeq_queue import lbmeq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    input  t_snap i_push,
    output logic  o_push_ready,
    output logic  o_pop_valid,
    output t_snap o_pop,
    input  logic  i_pop_ready
);

    t_snap      r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       w_push, w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop        = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid & o_push_ready;
    assign w_pop        = o_pop_valid & i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) r_wr_ptr <= ~r_wr_ptr;
            if (w_pop)  r_rd_ptr <= ~r_rd_ptr;
            case ({w_push, w_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != 2'd3))
        else $error("snapshot queue count out of range");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("snapshot queue pointers disagree with count");

endmodule

// ===== src/lbmeq_back.sv =====
`timescale 1ns / 1ps

module lbmeq_back import lbmeq_pkg::*; #(
    parameter int NUM_DIRS  = 19,
    parameter int FRAC_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_snap_valid,
    input  t_snap       i_snap,
    output logic        o_snap_ready,
    lbmeq_out_if.source o_out
);

    // Width of the squared terms after the fraction shift, of the numerator,
    // and of the byte-serial dividend.
    localparam int PW     = 64 - FRAC_BITS;
    localparam int NW     = PW + 5;
    localparam int STEPS  = (NW + 7) / 8;
    localparam int DVD_W  = STEPS * 8;
    localparam int SCNT_W = $clog2(STEPS);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ABSU = 4'd1;
    localparam logic [3:0] S_SQ   = 4'd2;
    localparam logic [3:0] S_CU   = 4'd3;
    localparam logic [3:0] S_ABS  = 4'd4;
    localparam logic [3:0] S_MUL  = 4'd5;
    localparam logic [3:0] S_NUM  = 4'd6;
    localparam logic [3:0] S_PREP = 4'd7;
    localparam logic [3:0] S_DIV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // Reciprocals for the quotient digit: floor(v * R / 2^15) equals v / 3 or v / 9
    // for every digit value that the divider can form.
    localparam logic [13:0] C_RECIP3 = 14'd10923;
    localparam logic [13:0] C_RECIP9 = 14'd3641;
    localparam int          C_RSH    = 15;

    function automatic logic signed [31:0] f_clamp32(t_acc v);
        if ((&v[C_ACC_W-1:31]) || !(|v[C_ACC_W-1:31])) begin
            return v[31:0];
        end
        return v[C_ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic [31:0] f_abs32(logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic signed [33:0] f_term(logic signed [1:0] c, logic signed [31:0] u);
        case (c)
            C_VEL_POS: return 34'(u);
            C_VEL_NEG: return -34'(u);
            default:   return 34'sd0;
        endcase
    endfunction

    logic [3:0]              r_state, n_state;
    logic [1:0]              r_cnt, n_cnt;
    logic [C_DIR_W-1:0]      r_q, n_q;
    logic [SCNT_W-1:0]       r_step, n_step;
    logic                    r_out_valid, n_out_valid;

    logic signed [31:0]      r_rho, r_ux, r_uy, r_uz;
    logic [31:0]             r_ax, r_ay, r_az;
    logic [63:0]             r_uu;
    logic [63:0]             r_prod;
    logic signed [33:0]      r_cu;
    logic [31:0]             r_m;
    logic [NW-1:0]           r_num;
    logic                    r_neg;
    logic                    r_d9;
    logic [DVD_W-1:0]        r_dvd;
    logic [DVD_W-1:0]        r_quo;
    logic [3:0]              r_rem;
    logic signed [C_OUT_W-1:0] r_eq;
    logic [C_DIR_W-1:0]      r_dir;
    logic                    r_last;

    logic [31:0]             w_mul_op;
    logic [63:0]             w_sq;
    t_vel                    w_vel;
    logic signed [33:0]      w_cu;
    logic [33:0]             w_cu_mag;
    logic [PW-1:0]           w_p, w_u;
    logic [NW-1:0]           w_num;
    logic [1:0]              w_cls;
    logic [6:0]              w_addend;
    logic [NW-1:0]           w_x;
    logic [NW-1:0]           w_y;
    logic [11:0]             w_v;
    logic [25:0]             w_vr;
    logic [7:0]              w_qd;
    logic [11:0]             w_qm;
    logic [11:0]             w_rem;
    logic signed [C_OUT_W-1:0] w_eq;
    logic                    w_slot;
    logic                    w_last_dir;

    // ---- shared 32x32 squarer ----
    always_comb begin
        if (r_state == S_SQ) begin
            case (r_cnt)
                2'd0:    w_mul_op = r_ax;
                2'd1:    w_mul_op = r_ay;
                default: w_mul_op = r_az;
            endcase
        end else begin
            w_mul_op = r_m;
        end
    end
    assign w_sq = w_mul_op * w_mul_op;

    // ---- c.u for the current direction ----
    assign w_vel    = f_vel(r_q);
    assign w_cu     = f_term(w_vel.cx, r_ux) + f_term(w_vel.cy, r_uy) + f_term(w_vel.cz, r_uz);
    assign w_cu_mag = r_cu[33] ? 34'(-r_cu) : 34'(r_cu);

    // ---- numerator 2 rho + 6 cu + 9 P - 3 U ----
    assign w_p   = PW'(r_prod >> FRAC_BITS);
    assign w_u   = PW'(r_uu >> FRAC_BITS);
    assign w_num = (NW'(r_rho) << 1) + (NW'(r_cu) << 2) + (NW'(r_cu) << 1)
                 + (NW'(w_p) << 3) + NW'(w_p) - (NW'(w_u) << 1) - NW'(w_u);

    // ---- magnitude plus half divisor, then the power-of-two part of the divisor ----
    always_comb begin
        if (r_q == '0) begin
            w_cls = 2'd0;
        end else if (r_q < C_DIR_W'(7)) begin
            w_cls = 2'd1;
        end else begin
            w_cls = 2'd2;
        end
        case (w_cls)
            2'd0:    w_addend = 7'd3;
            2'd1:    w_addend = 7'd18;
            default: w_addend = 7'd36;
        endcase
        // For a negative numerator, -n + h is formed as ~n + (h + 1).
        if (r_num[NW-1]) begin
            w_x = ~r_num + NW'(w_addend + 7'd1);
        end else begin
            w_x = r_num + NW'(w_addend);
        end
        case (w_cls)
            2'd0:    w_y = w_x >> 1;
            2'd1:    w_y = w_x >> 2;
            default: w_y = w_x >> 3;
        endcase
    end

    // ---- one quotient byte per cycle by 3 or 9 ----
    assign w_v   = {r_rem, r_dvd[DVD_W-1 -: 8]};
    assign w_vr  = 26'(w_v) * 26'(r_d9 ? C_RECIP9 : C_RECIP3);
    assign w_qd  = w_vr[C_RSH +: 8];
    assign w_qm  = r_d9 ? (12'({w_qd, 3'b000}) + 12'(w_qd)) : (12'({w_qd, 1'b0}) + 12'(w_qd));
    assign w_rem = w_v - w_qm;

    // ---- sign and saturation of the rounded quotient ----
    always_comb begin
        if (!r_neg) begin
            if (|r_quo[DVD_W-1:31]) w_eq = 32'sh7FFF_FFFF;
            else                    w_eq = $signed(r_quo[31:0]);
        end else begin
            if ((|r_quo[DVD_W-1:32]) || (r_quo[31] && (|r_quo[30:0]))) begin
                w_eq = 32'sh8000_0000;
            end else begin
                w_eq = $signed(32'(-r_quo[31:0]));
            end
        end
    end

    assign w_slot     = !r_out_valid || o_out.ready;
    assign w_last_dir = (r_q == C_DIR_W'(NUM_DIRS - 1));
    assign o_snap_ready = (r_state == S_IDLE);

    // ---- sequencer ----
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_q         = r_q;
        n_step      = r_step;
        n_out_valid = r_out_valid;
        if (r_out_valid && o_out.ready) n_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: if (i_snap_valid) n_state = S_ABSU;
            S_ABSU: begin
                n_state = S_SQ;
                n_cnt   = 2'd0;
            end
            S_SQ: begin
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    n_state = S_CU;
                    n_q     = '0;
                end
            end
            S_CU:   n_state = S_ABS;
            S_ABS:  n_state = S_MUL;
            S_MUL:  n_state = S_NUM;
            S_NUM:  n_state = S_PREP;
            S_PREP: begin
                n_state = S_DIV;
                n_step  = '0;
            end
            S_DIV: begin
                n_step = r_step + SCNT_W'(1);
                if (r_step == SCNT_W'(STEPS - 1)) n_state = S_OUT;
            end
            S_OUT: begin
                if (w_slot) begin
                    n_out_valid = 1'b1;
                    if (w_last_dir) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_CU;
                        n_q     = r_q + C_DIR_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= 2'd0;
            r_q         <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_q         <= n_q;
            r_step      <= n_step;
            r_out_valid <= n_out_valid;
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge i_clk) begin
        r_prod <= w_sq;
        case (r_state)
            S_IDLE: begin
                r_rho <= f_clamp32(i_snap.rho);
                r_ux  <= f_clamp32(i_snap.mx);
                r_uy  <= f_clamp32(i_snap.my);
                r_uz  <= f_clamp32(i_snap.mz);
            end
            S_ABSU: begin
                r_ax <= f_abs32(r_ux);
                r_ay <= f_abs32(r_uy);
                r_az <= f_abs32(r_uz);
                r_uu <= '0;
            end
            S_SQ: begin
                if (r_cnt != 2'd0) r_uu <= r_uu + r_prod;
            end
            S_CU:  r_cu <= w_cu;
            S_ABS: r_m  <= (|w_cu_mag[33:32]) ? 32'hFFFF_FFFF : w_cu_mag[31:0];
            S_NUM: r_num <= w_num;
            S_PREP: begin
                r_neg <= r_num[NW-1];
                r_d9  <= (w_cls != 2'd0);
                r_dvd <= DVD_W'(w_y);
                r_rem <= 4'd0;
            end
            S_DIV: begin
                r_dvd <= r_dvd << 8;
                r_quo <= {r_quo[DVD_W-9:0], w_qd};
                r_rem <= w_rem[3:0];
            end
            S_OUT: begin
                if (w_slot) begin
                    r_eq   <= w_eq;
                    r_dir  <= r_q;
                    r_last <= w_last_dir;
                end
            end
            default: ;
        endcase
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.equilibrium   = r_eq;
    assign o_out.out_direction = r_dir;
    assign o_out.last_out      = r_last;

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> ((r_d9 && r_rem < 4'd9) || (!r_d9 && r_rem < 4'd3)))
        else $error("divider remainder not below divisor");

    a_last_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last_out) |-> (o_out.out_direction == C_DIR_W'(NUM_DIRS - 1)))
        else $error("last mark on a direction other than the final one");

    a_dir_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_q < C_DIR_W'(NUM_DIRS)))
        else $error("direction counter ran past the lattice");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_snap_valid) |=> (r_state == S_ABSU))
        else $error("snapshot taken without starting a cell");

endmodule

// ===== src/lbm_equilibrium_d3q19_top.sv =====
`timescale 1ns / 1ps

// Port    Side  Handshake    Item contents
// i_in    in    valid/ready  population (s32, Q7.24), direction (u5), last_in (u1)
// o_out   out   valid/ready  equilibrium (s32, Q7.24), out_direction (u5), last_out (u1)
//
// The front takes one population per cycle whenever the two-cell snapshot queue has room.
// Per cell the back squares the velocity once, then for each direction forms c.u,
// squares it, builds the numerator and divides it byte-serially to a Q7.24 result.
// The synchronous reset clears the accumulators, the queue and the output valid flag.
// When o_out.ready is low the result stays in the output register and the back waits in
// its output step; the front keeps accepting items until the queue is full.

module lbm_equilibrium_d3q19_top import lbmeq_pkg::*; #(
    parameter int NUM_DIRS  = 19,
    parameter int FRAC_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lbmeq_in_if.sink    i_in,
    lbmeq_out_if.source o_out
);

    // Front to queue: the sums of a finished cell, including its last item.
    logic  w_fq_valid;
    logic  w_fq_ready;
    t_snap w_fq_snap;

    // Queue to back: the oldest finished cell waiting for its equilibria.
    logic  w_qb_valid;
    logic  w_qb_ready;
    t_snap w_qb_snap;

    // Saturating density and momentum sums, one item per cycle while the queue has room.
    lbmeq_front #(
        .NUM_DIRS (NUM_DIRS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_snap_valid (w_fq_valid),
        .o_snap       (w_fq_snap),
        .i_snap_ready (w_fq_ready)
    );

    // Two entries let the front gather the next cell while the back is still busy.
    lbmeq_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_fq_valid),
        .i_push       (w_fq_snap),
        .o_push_ready (w_fq_ready),
        .o_pop_valid  (w_qb_valid),
        .o_pop        (w_qb_snap),
        .i_pop_ready  (w_qb_ready)
    );

    // The back squares, combines and divides for each direction in turn and
    // presents the results through its output register.
    lbmeq_back #(
        .NUM_DIRS  (NUM_DIRS),
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_snap_valid (w_qb_valid),
        .i_snap       (w_qb_snap),
        .o_snap_ready (w_qb_ready),
        .o_out        (o_out)
    );

endmodule
